[rtl/core/erv_pkg.sv]
// Package: constants, types and the arctangent table for the Euler vector rotator.
`timescale 1ns / 1ps
package erv_pkg;
	localparam int VECTOR_WIDTH_DEF = 24;
	localparam int ANGLE_WIDTH_DEF  = 16;
	localparam int TRIG_STAGES_DEF  = 16;
	localparam int ATAN_COUNT       = 24;
	localparam int CW               = 34;   // CORDIC datapath width
	localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;
	localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

	typedef enum logic {
		OP_BODY  = 1'b0,
		OP_EARTH = 1'b1
	} op_t;

	// one CORDIC lane: x, y, residual angle
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} lane_t;

	// three lanes plus the flip marks of each angle
	typedef struct packed {
		lane_t [2:0] ln;
		logic  [2:0] flip;
	} trig_t;

	function automatic logic signed [CW-1:0] atan_val(input int i);
		logic signed [CW-1:0] r;
		begin
			case (i)
				0: r = 34'sd536870912;  1: r = 34'sd316933406;
				2: r = 34'sd167458907;  3: r = 34'sd85004756;
				4: r = 34'sd42667331;   5: r = 34'sd21354465;
				6: r = 34'sd10679838;   7: r = 34'sd5340245;
				8: r = 34'sd2670163;    9: r = 34'sd1335087;
				10: r = 34'sd667544;    11: r = 34'sd333772;
				12: r = 34'sd166886;    13: r = 34'sd83443;
				14: r = 34'sd41722;     15: r = 34'sd20861;
				16: r = 34'sd10430;     17: r = 34'sd5215;
				18: r = 34'sd2608;      19: r = 34'sd1304;
				20: r = 34'sd652;       21: r = 34'sd326;
				22: r = 34'sd163;       23: r = 34'sd81;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// floor((a*b + 2^29) / 2^30) for Q30 operands
	function automatic logic signed [CW-1:0] q30mul(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic signed [63:0] p;
		logic signed [63:0] s;
		begin
			p = 64'(a) * 64'(b);
			s = (p + HALF_Q30) >>> 30;
			return s[CW-1:0];
		end
	endfunction

	function automatic logic signed [CW-1:0] clamp_unit(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		begin
			if (v > ONE_Q30) r = ONE_Q30;
			else if (v < -ONE_Q30) r = -ONE_Q30;
			else r = v;
			return r;
		end
	endfunction
endpackage

[rtl/core/erv_cell.sv]
// One CORDIC iteration cell for three angle lanes, with the item's payload riding alongside.
`timescale 1ns / 1ps
module erv_cell #(
	parameter int STAGE   = 0,
	parameter int PAYLOAD = 73
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  erv_pkg::trig_t      trig_in,
	input  logic [PAYLOAD-1:0]  pay_in,
	output logic                vld_q,
	output erv_pkg::trig_t      trig_q,
	output logic [PAYLOAD-1:0]  pay_q
);
	erv_pkg::trig_t nxt;
	localparam logic signed [erv_pkg::CW-1:0] A = erv_pkg::atan_val(STAGE);

	always_comb begin
		nxt = trig_in;
		for (int l = 0; l < 3; l++) begin
			if (!trig_in.ln[l].z[erv_pkg::CW-1]) begin
				nxt.ln[l].x = trig_in.ln[l].x - (trig_in.ln[l].y >>> STAGE);
				nxt.ln[l].y = trig_in.ln[l].y + (trig_in.ln[l].x >>> STAGE);
				nxt.ln[l].z = trig_in.ln[l].z - A;
			end else begin
				nxt.ln[l].x = trig_in.ln[l].x + (trig_in.ln[l].y >>> STAGE);
				nxt.ln[l].y = trig_in.ln[l].y - (trig_in.ln[l].x >>> STAGE);
				nxt.ln[l].z = trig_in.ln[l].z + A;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_q <= nxt;
			pay_q  <= pay_in;
		end
	end
endmodule

[rtl/core/erv_mat.sv]
// Matrix build and vector product stages behind the CORDIC row.
`timescale 1ns / 1ps
module erv_mat #(
	parameter int VECTOR_WIDTH = erv_pkg::VECTOR_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           vld_in,
	input  erv_pkg::trig_t                 trig_in,
	input  logic [3*VECTOR_WIDTH:0]        pay_in,
	output logic                           vld_out,
	output logic signed [VECTOR_WIDTH-1:0] ox,
	output logic signed [VECTOR_WIDTH-1:0] oy,
	output logic signed [VECTOR_WIDTH-1:0] oz,
	output logic                           sat
);
	localparam int CW = erv_pkg::CW;
	localparam int PW = 3 * VECTOR_WIDTH + 1;
	localparam int AW = CW + VECTOR_WIDTH + 2;

	logic [4:0] vld_q;
	logic signed [CW-1:0] sc_s1 [6];          // sr cr sp cp sy cy
	logic [PW-1:0] pay_s1, pay_s2, pay_s3;
	logic signed [CW-1:0] p_s2 [9];           // pairs and first half of triples
	logic signed [CW-1:0] sc_s2 [6];
	logic signed [CW-1:0] m_s3 [9];
	logic signed [AW-1:0] pr_s4 [9];
	logic signed [CW-1:0] mc [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[3:0], vld_in};
	end
	assign vld_out = vld_q[4];

	// stage 1: undo the half-turn advance
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				sc_s1[2*l]   <= trig_in.flip[l] ? -trig_in.ln[l].y : trig_in.ln[l].y;
				sc_s1[2*l+1] <= trig_in.flip[l] ? -trig_in.ln[l].x : trig_in.ln[l].x;
			end
			pay_s1 <= pay_in;
		end
	end

	// stage 2: pair products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= erv_pkg::q30mul(sc_s1[3], sc_s1[5]);  // cp*cy
			p_s2[1] <= erv_pkg::q30mul(sc_s1[4], sc_s1[1]);  // sy*cr
			p_s2[2] <= erv_pkg::q30mul(sc_s1[0], sc_s1[2]);  // sr*sp
			p_s2[3] <= erv_pkg::q30mul(sc_s1[0], sc_s1[4]);  // sr*sy
			p_s2[4] <= erv_pkg::q30mul(sc_s1[2], sc_s1[1]);  // sp*cr
			p_s2[5] <= erv_pkg::q30mul(sc_s1[4], sc_s1[3]);  // sy*cp
			p_s2[6] <= erv_pkg::q30mul(sc_s1[1], sc_s1[5]);  // cr*cy
			p_s2[7] <= erv_pkg::q30mul(sc_s1[0], sc_s1[5]);  // sr*cy
			p_s2[8] <= erv_pkg::q30mul(sc_s1[2], sc_s1[4]);  // sp*sy
			sc_s2   <= sc_s1;
			pay_s2  <= pay_s1;
		end
	end

	// stage 3: triple products and matrix entries
	always_ff @(posedge clk) begin
		if (en) begin
			m_s3[0] <= erv_pkg::clamp_unit(p_s2[0]);
			m_s3[1] <= erv_pkg::clamp_unit(p_s2[1] + erv_pkg::q30mul(p_s2[2], sc_s2[5]));
			m_s3[2] <= erv_pkg::clamp_unit(-p_s2[3] + erv_pkg::q30mul(p_s2[4], sc_s2[5]));
			m_s3[3] <= erv_pkg::clamp_unit(-p_s2[5]);
			m_s3[4] <= erv_pkg::clamp_unit(p_s2[6] - erv_pkg::q30mul(p_s2[2], sc_s2[4]));
			m_s3[5] <= erv_pkg::clamp_unit(-p_s2[7] - erv_pkg::q30mul(p_s2[8], sc_s2[1]));
			m_s3[6] <= erv_pkg::clamp_unit(-sc_s2[2]);
			m_s3[7] <= erv_pkg::clamp_unit(erv_pkg::q30mul(sc_s2[0], sc_s2[3]));
			m_s3[8] <= erv_pkg::clamp_unit(erv_pkg::q30mul(sc_s2[1], sc_s2[3]));
			pay_s3  <= pay_s2;
		end
	end

	// stage 4: entry times component, transposed for the earth frame
	always_comb begin
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				mc[r*3+k] = (pay_s3[0] == erv_pkg::OP_EARTH) ? m_s3[k*3+r] : m_s3[r*3+k];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					pr_s4[r*3+k] <= AW'(mc[r*3+k]) *
						AW'($signed(pay_s3[1+k*VECTOR_WIDTH +: VECTOR_WIDTH]));
		end
	end

	// stage 5: sum, round, saturate
	logic signed [AW-1:0] acc [3];
	logic signed [AW-1:0] rnd [3];
	logic signed [VECTOR_WIDTH-1:0] res [3];
	logic [2:0] clip;
	localparam logic signed [AW-1:0] LIM_HI = AW'((64'sd1 <<< (VECTOR_WIDTH - 1)) - 1);
	localparam logic signed [AW-1:0] LIM_LO = -AW'(64'sd1 <<< (VECTOR_WIDTH - 1));
	localparam logic signed [AW-1:0] HALF = AW'(64'sd536870912);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = pr_s4[r*3] + pr_s4[r*3+1] + pr_s4[r*3+2];
			rnd[r] = (acc[r] + HALF) >>> 30;
			clip[r] = 1'b1;
			if (rnd[r] > LIM_HI) res[r] = LIM_HI[VECTOR_WIDTH-1:0];
			else if (rnd[r] < LIM_LO) res[r] = LIM_LO[VECTOR_WIDTH-1:0];
			else begin
				res[r] = rnd[r][VECTOR_WIDTH-1:0];
				clip[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox  <= res[0];
			oy  <= res[1];
			oz  <= res[2];
			sat <= |clip;
		end
	end
endmodule

[rtl/core/euler_rotate_vector_top.sv]
// Top level: Euler angle vector rotator, CORDIC cell row feeding the matrix stages.
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall  | opcode vec_x vec_y vec_z angle_*
//  out     | output    | out_valid/out_stall| out_x out_y out_z saturated
// One request per cycle while the pipe is not held; stages: an input load register,
// TRIG_STAGES CORDIC cells (capped at 24), then five matrix and product stages.
// Reset clears only valid flags; payload registers are not reset.
// The whole pipe holds while out_stall is high and the output holds a result;
// empty slots are not squeezed out: the whole pipe advances whenever the output is free.
`timescale 1ns / 1ps
module euler_rotate_vector_top #(
	parameter int VECTOR_WIDTH = erv_pkg::VECTOR_WIDTH_DEF,
	parameter int ANGLE_WIDTH  = erv_pkg::ANGLE_WIDTH_DEF,
	parameter int TRIG_STAGES  = erv_pkg::TRIG_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           opcode,
	input  logic signed [VECTOR_WIDTH-1:0] vec_x,
	input  logic signed [VECTOR_WIDTH-1:0] vec_y,
	input  logic signed [VECTOR_WIDTH-1:0] vec_z,
	input  logic signed [ANGLE_WIDTH-1:0]  angle_roll,
	input  logic signed [ANGLE_WIDTH-1:0]  angle_pitch,
	input  logic signed [ANGLE_WIDTH-1:0]  angle_yaw,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [VECTOR_WIDTH-1:0] out_x,
	output logic signed [VECTOR_WIDTH-1:0] out_y,
	output logic signed [VECTOR_WIDTH-1:0] out_z,
	output logic                           saturated
);
	localparam int CW = erv_pkg::CW;
	localparam int PW = 3 * VECTOR_WIDTH + 1;
	localparam int NS = (TRIG_STAGES < erv_pkg::ATAN_COUNT) ? TRIG_STAGES : erv_pkg::ATAN_COUNT;

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	erv_pkg::trig_t t0;
	logic [PW-1:0] p0;
	logic v_q;
	erv_pkg::trig_t trig_q;
	logic [PW-1:0] pay_q;

	// phase setup: angle into the top of a 32-bit phase, flip the side quarters
	always_comb begin
		logic [ANGLE_WIDTH-1:0] a [3];
		logic [31:0] ph;
		a[0] = angle_roll;
		a[1] = angle_pitch;
		a[2] = angle_yaw;
		for (int l = 0; l < 3; l++) begin
			ph = {a[l], {(32-ANGLE_WIDTH){1'b0}}};
			t0.flip[l] = ph[31] ^ ph[30];
			if (t0.flip[l]) ph = ph + 32'h8000_0000;
			t0.ln[l].x = erv_pkg::INV_GAIN_Q30;
			t0.ln[l].y = '0;
			t0.ln[l].z = CW'($signed(ph));
		end
	end
	assign p0 = {vec_z, vec_y, vec_x, opcode};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (en) v_q <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			trig_q <= t0;
			pay_q  <= p0;
		end
	end

	logic            cv [NS+1];
	erv_pkg::trig_t  ct [NS+1];
	logic [PW-1:0]   cp [NS+1];
	assign cv[0] = v_q;
	assign ct[0] = trig_q;
	assign cp[0] = pay_q;

	for (genvar g = 0; g < NS; g++) begin : g_cell
		erv_cell #(.STAGE(g), .PAYLOAD(PW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(cv[g]), .trig_in(ct[g]), .pay_in(cp[g]),
			.vld_q(cv[g+1]), .trig_q(ct[g+1]), .pay_q(cp[g+1])
		);
	end

	erv_mat #(.VECTOR_WIDTH(VECTOR_WIDTH)) u_mat (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(cv[NS]), .trig_in(ct[NS]), .pay_in(cp[NS]),
		.vld_out(out_valid), .ox(out_x), .oy(out_y), .oz(out_z), .sat(saturated)
	);

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(saturated))
		else $error("result dropped under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q))
		else $error("first stage moved while held");
`endif
endmodule

[tb/sv/euler_rotate_vector_checker.sv]
// Checker: watches both channels of the Euler vector rotator, predicts and compares results.
`timescale 1ns / 1ps
module euler_rotate_vector_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                opcode,
	input  logic signed [23:0]  vec_x,
	input  logic signed [23:0]  vec_y,
	input  logic signed [23:0]  vec_z,
	input  logic signed [15:0]  angle_roll,
	input  logic signed [15:0]  angle_pitch,
	input  logic signed [15:0]  angle_yaw,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic signed [23:0]  out_x,
	input  logic signed [23:0]  out_y,
	input  logic signed [23:0]  out_z,
	input  logic                saturated,
	output int                  fail_count,
	output int                  pending,
	output int                  rotated_count,
	output int                  clipped_count
);
	localparam int STAGES = 16;

	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic               sat;
	} rotated_t;

	rotated_t rotated_q[$];

	longint unsigned turn_table[24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	function automatic longint fixmul(input longint a, input longint b);
		return (a * b + 64'sd536870912) >>> 30;
	endfunction

	function automatic longint unit_clip(input longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	// sine and cosine of a binary angle, Q30
	task automatic angle_trig(input logic [15:0] ang, output longint s, output longint c);
		logic [31:0] phase;
		logic        flip;
		longint      x, y, z, dx, dy;
		phase = {ang, 16'h0};
		flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
		if (flip)
			phase = phase + 32'h8000_0000;
		z = longint'($signed(phase));
		x = 652032874;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(turn_table[i]);
			end else begin
				x += dx; y -= dy; z += longint'(turn_table[i]);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = x;
		s = y;
	endtask

	task automatic predict_rotation(input logic op, input logic signed [23:0] vx,
			input logic signed [23:0] vy, input logic signed [23:0] vz,
			input logic [15:0] ar, input logic [15:0] ap, input logic [15:0] ay,
			output rotated_t r);
		longint sr, cr, sp, cp, sy, cy, acc, res;
		longint m[9];
		longint v[3];
		logic signed [23:0] o[3];
		angle_trig(ar, sr, cr);
		angle_trig(ap, sp, cp);
		angle_trig(ay, sy, cy);
		v[0] = vx; v[1] = vy; v[2] = vz;
		m[0] = fixmul(cp, cy);
		m[1] = fixmul(sy, cr) + fixmul(fixmul(sr, sp), cy);
		m[2] = -fixmul(sr, sy) + fixmul(fixmul(sp, cr), cy);
		m[3] = -fixmul(sy, cp);
		m[4] = fixmul(cr, cy) - fixmul(fixmul(sr, sp), sy);
		m[5] = -fixmul(sr, cy) - fixmul(fixmul(sp, sy), cr);
		m[6] = -sp;
		m[7] = fixmul(sr, cp);
		m[8] = fixmul(cr, cp);
		r.sat = 1'b0;
		for (int k = 0; k < 9; k++)
			m[k] = unit_clip(m[k]);
		for (int row = 0; row < 3; row++) begin
			acc = 0;
			for (int k = 0; k < 3; k++)
				acc += m[(op == erv_pkg::OP_EARTH) ? (k * 3 + row) : (row * 3 + k)] * v[k];
			res = (acc + 64'sd536870912) >>> 30;
			if (res > 64'sd8388607) begin
				res = 64'sd8388607; r.sat = 1'b1;
			end
			if (res < -64'sd8388608) begin
				res = -64'sd8388608; r.sat = 1'b1;
			end
			o[row] = res[23:0];
		end
		r.x = o[0]; r.y = o[1]; r.z = o[2];
	endtask

	always @(posedge clk or negedge arst_n) begin
		rotated_t r;
		rotated_t e;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			rotated_count <= 0;
			clipped_count <= 0;
			rotated_q.delete();
		end else begin
			if (in_valid && !in_stall) begin
				predict_rotation(opcode, vec_x, vec_y, vec_z, angle_roll, angle_pitch,
					angle_yaw, r);
				rotated_q.push_back(r);
			end
			if (out_valid && !out_stall) begin
				if (rotated_q.size() == 0) begin
					$error("unexpected result x=%0d y=%0d z=%0d", out_x, out_y, out_z);
					fail_count <= fail_count + 1;
				end else begin
					e = rotated_q.pop_front();
					rotated_count <= rotated_count + 1;
					if (e.sat)
						clipped_count <= clipped_count + 1;
					if (out_x !== e.x || out_y !== e.y || out_z !== e.z
							|| saturated !== e.sat) begin
						if (out_x !== e.x)
							$error("out_x expected %0d got %0d", e.x, out_x);
						if (out_y !== e.y)
							$error("out_y expected %0d got %0d", e.y, out_y);
						if (out_z !== e.z)
							$error("out_z expected %0d got %0d", e.z, out_z);
						if (saturated !== e.sat)
							$error("saturated expected %0b got %0b", e.sat, saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= rotated_q.size();
		end
	end
endmodule

[tb/sv/euler_rotate_vector_top_tb.sv]
// Testbench top: drives requests into the Euler vector rotator and reports the verdict.
`timescale 1ns / 1ps
module euler_rotate_vector_top_tb;
	localparam int LATENCY = 22;
	localparam int WATCHDOG_LIMIT = 5000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = 1'b0;
	logic signed [23:0] vec_x = '0;
	logic signed [23:0] vec_y = '0;
	logic signed [23:0] vec_z = '0;
	logic signed [15:0] angle_roll = '0;
	logic signed [15:0] angle_pitch = '0;
	logic signed [15:0] angle_yaw = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [23:0] out_x;
	logic signed [23:0] out_y;
	logic signed [23:0] out_z;
	logic               saturated;
	int                 fail_count;
	int                 pending;
	int                 rotated_count;
	int                 clipped_count;
	int                 quiet_cycles = 0;
	bit                 calm = 1'b0;
	bit                 timed_out = 1'b0;
	bit                 settled = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	euler_rotate_vector_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.angle_roll(angle_roll), .angle_pitch(angle_pitch), .angle_yaw(angle_yaw),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated)
	);

	euler_rotate_vector_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.angle_roll(angle_roll), .angle_pitch(angle_pitch), .angle_yaw(angle_yaw),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated),
		.fail_count(fail_count), .pending(pending),
		.rotated_count(rotated_count), .clipped_count(clipped_count)
	);

	// random receiver stall, none during the calm stretch
	always @(posedge clk) begin
		if (arst_n)
			out_stall <= !calm && ($urandom_range(99) < 11);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic signed [23:0] pick_component(input bit extreme);
		int sel;
		if (!extreme)
			return 24'($urandom);
		sel = $urandom_range(4);
		case (sel)
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'sh000000;
			3: return 24'($urandom_range(255)) - 24'sd128;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_angle();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0: return 16'sh4000;
			1: return 16'shC000;
			2: return 16'sh8000;
			3: return 16'sh7FFF;
			4: return 16'($urandom_range(15) << 12);
			default: return 16'($urandom);
		endcase
	endfunction

	// present one request and hold it until accepted
	task automatic send_request(input logic op, input logic signed [23:0] x,
			input logic signed [23:0] y, input logic signed [23:0] z,
			input logic signed [15:0] r, input logic signed [15:0] p,
			input logic signed [15:0] w);
		while (!calm && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		vec_x <= x; vec_y <= y; vec_z <= z;
		angle_roll <= r; angle_pitch <= p; angle_yaw <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int n;
		int wait_count;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero angles, quarter turns, half turn, full-scale vectors
		for (int op = 0; op < 2; op++) begin
			send_request(erv_pkg::op_t'(op), 24'sd1000, -24'sd2000, 24'sd3000,
				16'sd0, 16'sd0, 16'sd0);
			send_request(erv_pkg::op_t'(op), 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
				16'sh1000, 16'sh1000, 16'sh1000);
			send_request(erv_pkg::op_t'(op), 24'sh800000, 24'sh800000, 24'sh800000,
				16'shF000, 16'shF000, 16'shF000);
			send_request(erv_pkg::op_t'(op), 24'sh7FFFFF, 24'sh800000, 24'sd1,
				16'sh4000, 16'sd0, 16'sd0);
			send_request(erv_pkg::op_t'(op), 24'sd12345, 24'sd678, -24'sd9,
				16'sd0, 16'shC000, 16'sd0);
			send_request(erv_pkg::op_t'(op), -24'sd1, 24'sh7FFFFF, 24'sd0,
				16'sd0, 16'sd0, 16'sh8000);
			send_request(erv_pkg::op_t'(op), 24'sh555555, 24'shAAAAAA, 24'sh7FFFFF,
				16'sh7FFF, 16'sh8000, 16'sh4000);
			send_request(erv_pkg::op_t'(op), 24'shAAAAAA, 24'sh555555, 24'sh800000,
				16'shC000, 16'sh7FFF, 16'shFFFF);
			send_request(erv_pkg::op_t'(op), 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
				16'sh2000, 16'sh2000, 16'sh2000);
			send_request(erv_pkg::op_t'(op), 24'sh800000, 24'sh7FFFFF, 24'sh800000,
				16'shE000, 16'sh6000, 16'shA000);
		end

		// hold off the sender until the pipe is empty
		drain_results();

		for (n = 0; n < 1400; n++) begin
			calm = (n >= 600 && n < 800);
			send_request(erv_pkg::op_t'($urandom_range(1)),
				pick_component($urandom_range(3) == 0),
				pick_component($urandom_range(3) == 0), pick_component($urandom_range(3) == 0),
				pick_angle(), pick_angle(), pick_angle());
			if (n == 900)
				drain_results();
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		wait_count = 0;
		while ((pending != 0 || !settled) && wait_count < 100000) begin
			@(posedge clk);
			wait_count++;
			if (pending == 0)
				settled = 1'b1;
		end
		repeat (LATENCY + 4) @(posedge clk);
		if (pending != 0)
			$error("%0d results never arrived", pending);

		$display("run covered %0d rotations in both frames, %0d of them clipped",
			rotated_count, clipped_count);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
